/* rtl/core/kpsd_pkg.sv */
// Shared types, codes and the matrix decode table of the keypad scan debounce core.
`default_nettype none

package kpsd_pkg;

    // Operation codes carried on the slave-side tuser.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    // Event sources.
    localparam logic [2:0] SRC_MATRIX = 3'd0;
    localparam logic [2:0] SRC_POWER  = 3'd1;
    localparam logic [2:0] SRC_CF     = 3'd2;
    localparam logic [2:0] SRC_MMC    = 3'd3;
    localparam logic [2:0] SRC_PEN    = 3'd4;

    // Key codes for the single-line sources and the empty code.
    localparam logic [7:0] CODE_NONE  = 8'hff;
    localparam logic [7:0] CODE_POWER = 8'h0e;
    localparam logic [7:0] CODE_CF    = 8'h10;
    localparam logic [7:0] CODE_MMC   = 8'h11;
    localparam logic [7:0] CODE_PEN   = 8'h0d;

    // Configuration reset and match counter ceiling.
    localparam logic [3:0] MATCHES_RESET = 4'd3;
    localparam logic [3:0] MATCH_MAX     = 4'd15;

    // Depth of the queue between the front and the back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Beat widths on the stream ports.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 24;

    // Matrix code for each bit 4*phase+row.
    localparam logic [7:0] KEY_TABLE [16] = '{
        8'h0c, 8'h02, 8'h01, 8'h00,
        8'h06, 8'h05, 8'h04, 8'h03,
        8'hff, 8'h0f, 8'h08, 8'h07,
        8'hff, 8'h0a, 8'h0b, 8'h09
    };

    // One classified item as it travels through the queue.
    typedef struct packed {
        t_op        op;
        logic [2:0] src;
        logic [7:0] mcode;
        logic [3:0] lines;
    } t_item;

    // Highest set bit of the matrix sample selects the code.
    function automatic logic [7:0] decode_matrix(input logic [15:0] rows);
        logic [7:0] code;
        code = CODE_NONE;
        for (int b = 0; b < 16; b++) begin
            if (rows[b]) begin
                code = KEY_TABLE[b];
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/kpsd_front.sv */
// Front end: takes input beats, drops meaningless operations and decodes the matrix sample.
`default_nettype none

module kpsd_front (
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [kpsd_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [kpsd_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  wire logic                           i_fifo_full,
    output logic                                o_push,
    output kpsd_pkg::t_item                     o_item
);

    logic [1:0] w_op;
    logic       w_keep;

    assign w_op = i_s_tuser[1:0];

    // Only tick, start and sample operations reach the back end.
    always_comb begin
        case (w_op)
            kpsd_pkg::OP_TICK,
            kpsd_pkg::OP_START,
            kpsd_pkg::OP_SAMPLE: w_keep = 1'b1;
            default:             w_keep = 1'b0;
        endcase
    end

    assign o_s_tready = !i_fifo_full;
    assign o_push     = i_s_tvalid && !i_fifo_full && w_keep;

    // Decode the matrix here so the back end only compares codes.
    always_comb begin
        o_item.op    = kpsd_pkg::t_op'(w_op);
        o_item.src   = i_s_tuser[4:2];
        o_item.mcode = kpsd_pkg::decode_matrix(i_s_tdata[15:0]);
        o_item.lines = i_s_tdata[19:16];
    end

endmodule

`default_nettype wire

/* rtl/core/kpsd_fifo.sv */
// Two-entry queue of classified items between the front and the back end.
`default_nettype none

module kpsd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire kpsd_pkg::t_item i_item,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_not_empty,
    output kpsd_pkg::t_item      o_item
);

    kpsd_pkg::t_item                r_mem [kpsd_pkg::FIFO_DEPTH];
    logic [kpsd_pkg::FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [kpsd_pkg::FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [kpsd_pkg::FIFO_CNT_W-1:0] r_count, n_count;

    assign o_full      = (r_count == kpsd_pkg::FIFO_CNT_W'(kpsd_pkg::FIFO_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == kpsd_pkg::FIFO_PTR_W'(kpsd_pkg::FIFO_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == kpsd_pkg::FIFO_PTR_W'(kpsd_pkg::FIFO_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/kpsd_back.sv */
// Back end: debounce state, card flags, configuration register and the result register.
`default_nettype none

module kpsd_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [3:0]                     i_cfg_wdata,
    input  wire logic                           i_item_valid,
    input  wire kpsd_pkg::t_item                i_item,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [kpsd_pkg::M_TDATA_W-1:0]      o_m_tdata
);

    logic [3:0]  r_matches;
    logic [7:0]  r_candidate, n_candidate;
    logic [3:0]  r_count, n_count;
    logic [2:0]  r_source, n_source;
    logic        r_busy, n_busy;
    logic        r_ticked, n_ticked;
    logic        r_cf, n_cf;
    logic        r_mmc, n_mmc;
    logic        r_out_valid, n_out_valid;
    logic [kpsd_pkg::M_TDATA_W-1:0] r_out_data;

    logic        w_emit;
    logic [7:0]  w_code;
    logic [3:0]  w_count;

    assign o_pop      = i_item_valid && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Sample decode for the source of the open run.
    always_comb begin
        case (r_source)
            kpsd_pkg::SRC_POWER: w_code = i_item.lines[1] ? kpsd_pkg::CODE_NONE
                                                          : kpsd_pkg::CODE_POWER;
            kpsd_pkg::SRC_CF:    w_code = i_item.lines[2] ? kpsd_pkg::CODE_NONE
                                                          : kpsd_pkg::CODE_CF;
            kpsd_pkg::SRC_MMC:   w_code = i_item.lines[3] ? kpsd_pkg::CODE_MMC
                                                          : kpsd_pkg::CODE_NONE;
            kpsd_pkg::SRC_PEN:   w_code = i_item.lines[0] ? kpsd_pkg::CODE_NONE
                                                          : kpsd_pkg::CODE_PEN;
            default:             w_code = i_item.mcode;
        endcase
    end

    // Saturating count of samples equal to their predecessor.
    always_comb begin
        if (w_code == r_candidate) begin
            w_count = (r_count < kpsd_pkg::MATCH_MAX) ? r_count + 1'b1 : r_count;
        end else begin
            w_count = '0;
        end
    end

    // Execute one item per pop.
    always_comb begin
        n_candidate = r_candidate;
        n_count     = r_count;
        n_source    = r_source;
        n_busy      = r_busy;
        n_ticked    = r_ticked;
        n_cf        = r_cf;
        n_mmc       = r_mmc;
        w_emit      = 1'b0;
        if (o_pop) begin
            case (i_item.op)
                kpsd_pkg::OP_TICK: begin
                    n_ticked = 1'b1;
                end
                kpsd_pkg::OP_START: begin
                    if (r_ticked) begin
                        n_candidate = i_item.mcode;
                        n_count     = '0;
                        n_source    = i_item.src;
                        n_busy      = 1'b1;
                    end
                end
                kpsd_pkg::OP_SAMPLE: begin
                    if (r_busy) begin
                        n_candidate = w_code;
                        n_count     = w_count;
                        if (w_count >= r_matches) begin
                            w_emit   = 1'b1;
                            n_busy   = 1'b0;
                            n_ticked = 1'b0;
                            n_count  = '0;
                            if (r_source == kpsd_pkg::SRC_CF) begin
                                n_cf = (w_code == kpsd_pkg::CODE_CF);
                            end else if (r_source == kpsd_pkg::SRC_MMC) begin
                                n_mmc = (w_code == kpsd_pkg::CODE_MMC);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_out_valid = w_emit || (r_out_valid && !i_m_tready);
    end

    // Control and debounce state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matches   <= kpsd_pkg::MATCHES_RESET;
            r_candidate <= kpsd_pkg::CODE_NONE;
            r_count     <= '0;
            r_source    <= kpsd_pkg::SRC_MATRIX;
            r_busy      <= 1'b0;
            r_ticked    <= 1'b0;
            r_cf        <= 1'b0;
            r_mmc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_matches <= i_cfg_wdata;
            end
            r_candidate <= n_candidate;
            r_count     <= n_count;
            r_source    <= n_source;
            r_busy      <= n_busy;
            r_ticked    <= n_ticked;
            r_cf        <= n_cf;
            r_mmc       <= n_mmc;
            r_out_valid <= n_out_valid;
        end
    end

    // Result beat: code, flags and the packed status word.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= {2'b00, n_mmc, n_cf, 2'b00, w_code, n_mmc, n_cf, w_code};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/keypad_scan_debounce_core.sv */
// Top level of the keypad scan debounce core: front end, queue and back end.
//
// Usage:
//   The slave stream carries events. tuser holds operation (tick, start with
//   reference sample, further sample) and source; tdata holds the matrix sample
//   and the raw single-line levels. The master stream carries one beat for each
//   accepted key code, with the card presence flags and the packed status word.
//   The one-register configuration port sets the number of matching samples;
//   it is to be written only while the core is idle; the core does not enforce this.
// Throughput:
//   One beat per cycle on the slave side while the queue has room; the back end
//   takes no item while a result waits on a stalled master side. A beat is queued,
//   executed by the back end and, if it completes a debounce run, registered and
//   shown on the master side. The back end's decode-and-compare sets the rate.
// Reset:
//   Synchronous, active low. The queue empties, the flags clear, the match
//   requirement returns to three and no run is open.
// Stall:
//   While the master side is stalled the result holds in its register and the
//   back end takes nothing more from the queue; the two-entry queue takes new
//   beats until it fills, then tready drops.
`default_nettype none

module keypad_scan_debounce_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [3:0]                     i_cfg_wdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] matrix_rows, [19:16] line_levels, [23:20] zero
    input  wire logic [kpsd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] operation, [4:2] source
    input  wire logic [kpsd_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] key_code, [8] cf_present, [9] mmc_present, [21:10] status_word, [23:22] zero
    output logic [kpsd_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_not_empty;
    kpsd_pkg::t_item w_front_item;
    kpsd_pkg::t_item w_back_item;

    // Accept and classify.
    kpsd_front u_front (
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_fifo_full (w_full),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    // Queue between the two halves.
    kpsd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_front_item),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_not_empty (w_not_empty),
        .o_item      (w_back_item)
    );

    // Debounce and result generation.
    kpsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (w_not_empty),
        .i_item       (w_back_item),
        .o_pop        (w_pop),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata)
    );

    // The status word repeats the code and the flags of the same beat.
    a_status_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:10] == m_axis_tdata[7:0])
                       && (m_axis_tdata[20] == m_axis_tdata[8])
                       && (m_axis_tdata[21] == m_axis_tdata[9])
                       && (m_axis_tdata[19:18] == 2'b00))
        else $error("status word does not match code and flags");

    // The queue is empty straight after reset, so the slave side is ready.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("slave side not ready after reset");

    // A new result only ever follows an item taken from the queue.
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_pop))
        else $error("result appeared without an executed item");

endmodule

`default_nettype wire
